### sv/ffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and codes of the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // default arena geometry
  localparam int DEF_HEAP_UNITS = 4096;
  localparam int DEF_UNIT_BYTES = 16;

  // fixed field widths
  localparam int ADDR_W  = 12;
  localparam int BYTES_W = 16;
  localparam int CFG_W   = 12;
  localparam int STAT_W  = 2;

  // working width for sizes, sums and compares (covers 16-bit arena + 17-bit need)
  localparam int XW = 18;

  localparam logic [CFG_W-1:0] MGU_RESET = CFG_W'(1024);

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOMEM   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd3;

endpackage

### sv/first_fit_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// First-fit allocator over an address-ordered circular free list whose headers
// live in one synchronous RAM; the break grows the arena on a miss.
// ----------------------------------------------------------------------------
// Sequence: alloc walks the free list from the rover, plus a state for a split;
//   a miss grows the break, inserts the new block by address, then searches
//   again. Free checks the header, then inserts; an upper join adds a state.
// Throughput: one item at a time; the header RAM read port (one header per
//   cycle) sets the walk speed, so rate follows list fragmentation.
// Reset: synchronous; rover 0, list not started, break at unit 1, grow 1024.
//   Header RAM is not cleared; entries are written before they are used.
// UNIT_BYTES must be a power of two.
module first_fit_free_list_allocator #(
  parameter int HEAP_UNITS = ffa_pkg::DEF_HEAP_UNITS,
  parameter int UNIT_BYTES = ffa_pkg::DEF_UNIT_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] request_bytes, [27:16] block_address
  input  logic [0:0]  s_axis_tuser,  // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [11:0] result_address, [13:12] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ffa_pkg::CFG_W-1:0] cfg_data
);
  import ffa_pkg::*;

  localparam int AW         = $clog2(HEAP_UNITS);
  localparam int BW         = $clog2(HEAP_UNITS + 1);
  localparam int SW         = BW;
  localparam int EW         = AW + SW;
  localparam int UB_SH      = $clog2(UNIT_BYTES);
  localparam int WALK_LIMIT = 2 * HEAP_UNITS + 8;
  localparam int WCW        = $clog2(WALK_LIMIT + 2);

  // state codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_A_ROV   = 4'd1;
  localparam logic [3:0] S_A_ROV_D = 4'd2;
  localparam logic [3:0] S_A_CHK   = 4'd3;
  localparam logic [3:0] S_A_SPLIT = 4'd4;
  localparam logic [3:0] S_G_ROV   = 4'd5;
  localparam logic [3:0] S_G_ROV_D = 4'd6;
  localparam logic [3:0] S_I_START = 4'd7;
  localparam logic [3:0] S_I_WALK  = 4'd8;
  localparam logic [3:0] S_I_UP    = 4'd9;
  localparam logic [3:0] S_I_LOW   = 4'd10;
  localparam logic [3:0] S_R_HDR   = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  // registers
  logic [3:0]        state, state_next;
  logic [XW-1:0]     need, need_next;
  logic [AW-1:0]     haddr, haddr_next;
  logic [SW-1:0]     hsize, hsize_next;
  logic [AW-1:0]     prev, prev_next;
  logic [SW-1:0]     prev_size, prev_size_next;
  logic [AW-1:0]     cur, cur_next;
  logic [SW-1:0]     cur_size, cur_size_next;
  logic [AW-1:0]     new_nx, new_nx_next;
  logic [SW-1:0]     new_size, new_size_next;
  logic [AW-1:0]     rover, rover_next;
  logic              started, started_next;
  logic [BW-1:0]     break_pt, break_pt_next;
  logic [CFG_W-1:0]  mgu;
  logic [WCW-1:0]    steps, steps_next;
  logic [WCW-1:0]    wcnt, wcnt_next;
  logic              is_alloc, is_alloc_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic              out_valid;
  logic [ADDR_W-1:0] out_addr;
  logic [STAT_W-1:0] out_status;

  // header RAM controls
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] rd_data, wr_data;
  logic [AW-1:0] rd_nx;
  logic [SW-1:0] rd_sz;

  // request decode
  logic [BYTES_W-1:0] in_bytes;
  logic [ADDR_W-1:0]  in_addr;
  logic [XW-1:0]      in_need, in_h, amount, split_sz;
  logic               in_take, slot_free, ins_exit;

  assign in_bytes  = s_axis_tdata[15:0];
  assign in_addr   = s_axis_tdata[27:16];
  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign in_need   = ((XW'(in_bytes) + XW'(UNIT_BYTES - 1)) >> UB_SH) + XW'(1);
  assign in_h      = XW'(in_addr) - XW'(1);
  assign amount    = (need < XW'(mgu)) ? XW'(mgu) : need;
  assign split_sz  = XW'(rd_sz) - need;
  assign rd_nx     = rd_data[EW-1:SW];
  assign rd_sz     = rd_data[SW-1:0];
  assign slot_free = !out_valid || m_axis_tready;
  assign ins_exit  = (haddr > cur && haddr < rd_nx) ||
                     (cur >= rd_nx && (haddr > cur || haddr < rd_nx));

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_status, out_addr};

  ffa_hdr_ram #(
    .DEPTH (HEAP_UNITS),
    .AW    (AW),
    .DW    (EW)
  ) u_hdr_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // sequencer: walks the list one header read per cycle
  always_comb begin
    state_next      = state;
    need_next       = need;
    haddr_next      = haddr;
    hsize_next      = hsize;
    prev_next       = prev;
    prev_size_next  = prev_size;
    cur_next        = cur;
    cur_size_next   = cur_size;
    new_nx_next     = new_nx;
    new_size_next   = new_size;
    rover_next      = rover;
    started_next    = started;
    break_pt_next   = break_pt;
    steps_next      = steps;
    wcnt_next       = wcnt;
    is_alloc_next   = is_alloc;
    res_addr_next   = res_addr;
    res_status_next = res_status;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;

    case (state)
      S_IDLE: begin
        if (in_take) begin
          need_next     = in_need;
          steps_next    = '0;
          res_addr_next = '0;
          if (s_axis_tuser[0] == CMD_ALLOC) begin
            is_alloc_next = 1'b1;
            if (in_need == XW'(1)) begin
              res_status_next = STAT_ZERO;
              state_next      = S_DONE;
            end else begin
              if (!started) begin
                // base sentinel: empty block at unit 0 pointing at itself
                wr_en        = 1'b1;
                wr_addr      = '0;
                wr_data      = '0;
                rover_next   = '0;
                started_next = 1'b1;
              end
              state_next = S_A_ROV;
            end
          end else begin
            is_alloc_next = 1'b0;
            if (!started || in_addr == '0 || in_h >= XW'(break_pt)) begin
              res_status_next = STAT_IGNORED;
              state_next      = S_DONE;
            end else begin
              haddr_next = AW'(in_h);
              rd_en      = 1'b1;
              rd_addr    = AW'(in_h);
              state_next = S_R_HDR;
            end
          end
        end
      end

      S_A_ROV: begin
        rd_en      = 1'b1;
        rd_addr    = rover;
        state_next = S_A_ROV_D;
      end

      S_A_ROV_D: begin
        prev_next      = rover;
        prev_size_next = rd_sz;
        cur_next       = rd_nx;
        rd_en          = 1'b1;
        rd_addr        = rd_nx;
        state_next     = S_A_CHK;
      end

      // header of cur is on rd_data
      S_A_CHK: begin
        if (XW'(rd_sz) >= need) begin
          if (XW'(rd_sz) == need) begin
            // exact fit: unlink
            wr_en           = 1'b1;
            wr_addr         = prev;
            wr_data         = {rd_nx, prev_size};
            rover_next      = prev;
            res_addr_next   = ADDR_W'(XW'(cur) + XW'(1));
            res_status_next = STAT_OK;
            state_next      = S_DONE;
          end else begin
            // shrink and carve the tail
            wr_en      = 1'b1;
            wr_addr    = cur;
            wr_data    = {rd_nx, SW'(split_sz)};
            cur_next   = AW'(XW'(cur) + split_sz);
            state_next = S_A_SPLIT;
          end
        end else if (cur == rover) begin
          // full lap without a fit: grow the break, or report no memory if it would pass the arena
          if (XW'(break_pt) + amount > XW'(HEAP_UNITS)) begin
            res_status_next = STAT_NOMEM;
            state_next      = S_DONE;
          end else begin
            wr_en         = 1'b1;
            wr_addr       = AW'(break_pt);
            wr_data       = {{AW{1'b0}}, SW'(amount)};
            haddr_next    = AW'(break_pt);
            hsize_next    = SW'(amount);
            break_pt_next = BW'(XW'(break_pt) + amount);
            state_next    = S_I_START;
          end
        end else begin
          prev_next      = cur;
          prev_size_next = rd_sz;
          cur_next       = rd_nx;
          steps_next     = steps + WCW'(1);
          if (steps + WCW'(1) > WCW'(WALK_LIMIT)) begin
            res_status_next = STAT_NOMEM;
            state_next      = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rd_nx;
          end
        end
      end

      S_A_SPLIT: begin
        wr_en           = 1'b1;
        wr_addr         = cur;
        wr_data         = {{AW{1'b0}}, SW'(need)};
        rover_next      = prev;
        res_addr_next   = ADDR_W'(XW'(cur) + XW'(1));
        res_status_next = STAT_OK;
        state_next      = S_DONE;
      end

      S_G_ROV: begin
        rd_en      = 1'b1;
        rd_addr    = rover;
        state_next = S_G_ROV_D;
      end

      S_G_ROV_D: begin
        prev_next      = rover;
        prev_size_next = rd_sz;
        cur_next       = rd_nx;
        steps_next     = steps + WCW'(1);
        if (steps + WCW'(1) > WCW'(WALK_LIMIT)) begin
          res_status_next = STAT_NOMEM;
          state_next      = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = rd_nx;
          state_next = S_A_CHK;
        end
      end

      // insertion of block haddr/hsize in address order
      S_I_START: begin
        cur_next   = rover;
        wcnt_next  = '0;
        rd_en      = 1'b1;
        rd_addr    = rover;
        state_next = S_I_WALK;
      end

      S_I_WALK: begin
        if (ins_exit) begin
          cur_size_next = rd_sz;
          if (XW'(haddr) + XW'(hsize) == XW'(rd_nx)) begin
            rd_en      = 1'b1;
            rd_addr    = rd_nx;
            state_next = S_I_UP;
          end else begin
            new_nx_next   = rd_nx;
            new_size_next = hsize;
            wr_en         = 1'b1;
            wr_addr       = haddr;
            wr_data       = {rd_nx, hsize};
            state_next    = S_I_LOW;
          end
        end else begin
          cur_next  = rd_nx;
          wcnt_next = wcnt + WCW'(1);
          if (wcnt + WCW'(1) > WCW'(WALK_LIMIT)) begin
            res_status_next = is_alloc ? STAT_NOMEM : STAT_IGNORED;
            state_next      = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rd_nx;
          end
        end
      end

      // join with upper neighbor
      S_I_UP: begin
        new_nx_next   = rd_nx;
        new_size_next = hsize + rd_sz;
        wr_en         = 1'b1;
        wr_addr       = haddr;
        wr_data       = {rd_nx, SW'(hsize + rd_sz)};
        state_next    = S_I_LOW;
      end

      // join with lower neighbor or link it in
      S_I_LOW: begin
        wr_en   = 1'b1;
        wr_addr = cur;
        if (XW'(cur) + XW'(cur_size) == XW'(haddr)) begin
          wr_data = {new_nx, SW'(cur_size + new_size)};
        end else begin
          wr_data = {haddr, cur_size};
        end
        rover_next = cur;
        if (is_alloc) begin
          state_next = S_G_ROV;
        end else begin
          res_status_next = STAT_OK;
          state_next      = S_DONE;
        end
      end

      S_R_HDR: begin
        if (rd_sz == '0 || XW'(haddr) + XW'(rd_sz) > XW'(break_pt)) begin
          res_status_next = STAT_IGNORED;
          state_next      = S_DONE;
        end else begin
          hsize_next = rd_sz;
          state_next = S_I_START;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rover     <= '0;
      started   <= 1'b0;
      break_pt  <= BW'(1);
      mgu       <= MGU_RESET;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rover    <= rover_next;
      started  <= started_next;
      break_pt <= break_pt_next;
      if (cfg_valid && cfg_ready) begin
        mgu <= cfg_data;
      end
      if (state == S_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    need       <= need_next;
    haddr      <= haddr_next;
    hsize      <= hsize_next;
    prev       <= prev_next;
    prev_size  <= prev_size_next;
    cur        <= cur_next;
    cur_size   <= cur_size_next;
    new_nx     <= new_nx_next;
    new_size   <= new_size_next;
    steps      <= steps_next;
    wcnt       <= wcnt_next;
    is_alloc   <= is_alloc_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
    if (state == S_DONE && slot_free) begin
      out_addr   <= res_addr;
      out_status <= res_status;
    end
  end

  // checks
  a_brk_range: assert property (@(posedge clk) disable iff (rst)
    break_pt >= BW'(1) && XW'(break_pt) <= XW'(HEAP_UNITS))
    else $error("break outside arena");

  a_brk_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> break_pt >= $past(break_pt))
    else $error("break moved down");

  a_started_sticky: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("list start flag dropped");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_DONE)
    else $error("result shown without finished item");

endmodule

### sv/ffa_hdr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_hdr_ram
// Block header store: one write port, one registered read port. Entries at or
// above DEPTH read as zero and writes there are dropped.
// ----------------------------------------------------------------------------
module ffa_hdr_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 25
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] mem_q;
  logic          oor_q;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en && ({1'b0, wr_addr} < (AW+1)'(DEPTH))) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      oor_q <= !({1'b0, rd_addr} < (AW+1)'(DEPTH));
      if ({1'b0, rd_addr} < (AW+1)'(DEPTH)) begin
        mem_q <= mem[rd_addr];
      end
    end
  end

  assign rd_data = oor_q ? '0 : mem_q;

endmodule
